@@ rtl/ccs_pkg.sv @@
// Shared types, codes and constants of the capacitor charge sequencer.
package ccs_pkg;

    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned THRESH_W  = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Sequencer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_BUCK  = 3'd1,
        MODE_BOOST = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_ERROR = 3'd4
    } t_mode;

    // Converter burst codes
    typedef enum logic [1:0] {
        BURST_NONE  = 2'd0,
        BURST_BUCK  = 2'd1,
        BURST_BOOST = 2'd2
    } t_burst;

    // Kick request codes
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_STRAIGHT = 2'd1;
    localparam logic [1:0] KIND_CHIP     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_FLOOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_RESUME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MARGIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUCK_STEPS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOOST_STEPS = 3'd7;

    // Configuration reset values
    localparam logic [7:0]         RST_STOP_LEVEL      = 8'd200;
    localparam logic [7:0]         RST_RESTART_LEVEL   = 8'd197;
    localparam logic [7:0]         RST_KICK_FLOOR      = 8'd150;
    localparam logic [7:0]         RST_SUPPLY_LOW      = 8'd130;
    localparam logic [7:0]         RST_SUPPLY_RESUME   = 8'd140;
    localparam logic [7:0]         RST_BOOST_MARGIN    = 8'd20;
    localparam logic [COUNT_W-1:0] RST_MAX_BUCK_STEPS  = 13'd300;
    localparam logic [COUNT_W-1:0] RST_MAX_BOOST_STEPS = 13'd6000;

    localparam logic [7:0] POWER_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]         stop_level;
        logic [7:0]         restart_level;
        logic [7:0]         kick_floor;
        logic [7:0]         supply_low;
        logic [7:0]         supply_resume;
        logic [7:0]         boost_margin;
        logic [COUNT_W-1:0] max_buck_steps;
        logic [COUNT_W-1:0] max_boost_steps;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  supply_tenths;
        logic [7:0]  cap_volts;
        logic        charge_enable;
        logic [1:0]  kick_kind;
        logic [15:0] kick_strength;
    } t_item;

    typedef struct packed {
        t_burst     burst;
        logic       kick_fire;
        logic       kick_direct;
        logic [7:0] kick_power;
        t_mode      mode;
        logic       charging;
        logic       fault;
    } t_result;

endpackage

@@ rtl/ccs_cfg_regs.sv @@
// Configuration register file of the capacitor charge sequencer.
module ccs_cfg_regs
    import ccs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load reset values, then take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_level      <= RST_STOP_LEVEL;
            r_cfg.restart_level   <= RST_RESTART_LEVEL;
            r_cfg.kick_floor      <= RST_KICK_FLOOR;
            r_cfg.supply_low      <= RST_SUPPLY_LOW;
            r_cfg.supply_resume   <= RST_SUPPLY_RESUME;
            r_cfg.boost_margin    <= RST_BOOST_MARGIN;
            r_cfg.max_buck_steps  <= RST_MAX_BUCK_STEPS;
            r_cfg.max_boost_steps <= RST_MAX_BOOST_STEPS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_STOP_LEVEL:      r_cfg.stop_level      <= i_cfg_data[7:0];
                CFG_RESTART_LEVEL:   r_cfg.restart_level   <= i_cfg_data[7:0];
                CFG_KICK_FLOOR:      r_cfg.kick_floor      <= i_cfg_data[7:0];
                CFG_SUPPLY_LOW:      r_cfg.supply_low      <= i_cfg_data[7:0];
                CFG_SUPPLY_RESUME:   r_cfg.supply_resume   <= i_cfg_data[7:0];
                CFG_BOOST_MARGIN:    r_cfg.boost_margin    <= i_cfg_data[7:0];
                CFG_MAX_BUCK_STEPS:  r_cfg.max_buck_steps  <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_BOOST_STEPS: r_cfg.max_boost_steps <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ccs_step_logic.sv @@
// Next-state and result logic for one control tick of the charge sequencer.
module ccs_step_logic
    import ccs_pkg::*;
(
    input  t_mode              i_mode,
    input  logic [COUNT_W-1:0] i_count,
    input  t_item              i_item,
    input  t_cfg               i_cfg,
    output t_result            o_res,
    output logic [COUNT_W-1:0] o_count
);

    t_mode               m;
    logic [COUNT_W-1:0]  cnt;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [THRESH_W-1:0] boost_thresh;
    t_burst              burst;
    logic                kick;
    logic                kick_ok;
    logic                straight;
    logic [7:0]          power;

    // Saturating step counter
    assign cnt_inc = (i_count == COUNT_MAX) ? i_count : i_count + 1'b1;

    // Buck-to-boost threshold: ten times cap volts plus margin
    assign boost_thresh = {1'b0, i_item.cap_volts, 3'b000}
                        + {3'b000, i_item.cap_volts, 1'b0}
                        + {4'b0000, i_cfg.boost_margin};

    assign kick_ok = (i_cfg.kick_floor <= i_item.cap_volts) && (i_item.kick_kind != KIND_NONE);

    // Step the sequencer
    always_comb begin
        m        = i_mode;
        cnt      = i_count;
        burst    = BURST_NONE;
        kick     = 1'b0;
        straight = 1'b0;
        power    = '0;
        if (m > MODE_ERROR) begin
            m = MODE_ERROR;
        end
        if (!i_item.charge_enable && m != MODE_ERROR) begin
            m = MODE_IDLE;
        end
        case (m)
            MODE_IDLE: begin
                if (i_item.charge_enable && i_cfg.supply_resume <= i_item.supply_tenths) begin
                    cnt = '0;
                    m   = MODE_BUCK;
                end
            end
            MODE_BUCK: begin
                if (i_item.supply_tenths <= i_cfg.supply_low) begin
                    m = MODE_IDLE;
                end else if ({4'b0000, i_item.supply_tenths} <= boost_thresh) begin
                    cnt = '0;
                    m   = MODE_BOOST;
                end else begin
                    cnt   = cnt_inc;
                    burst = BURST_BUCK;
                    if (i_cfg.max_buck_steps <= cnt_inc) begin
                        m = MODE_ERROR;
                    end
                end
            end
            MODE_BOOST: begin
                if (i_item.supply_tenths <= i_cfg.supply_low) begin
                    m = MODE_IDLE;
                end else if (i_cfg.stop_level <= i_item.cap_volts) begin
                    m = MODE_STOP;
                end else if (kick_ok) begin
                    kick = 1'b1;
                end else begin
                    cnt   = cnt_inc;
                    burst = BURST_BOOST;
                    if (i_cfg.max_boost_steps <= cnt_inc) begin
                        m = MODE_ERROR;
                    end
                end
            end
            MODE_STOP: begin
                if (i_item.cap_volts <= i_cfg.restart_level) begin
                    cnt = '0;
                    m   = MODE_BUCK;
                end else if (kick_ok) begin
                    kick = 1'b1;
                end
            end
            MODE_ERROR: begin
            end
            default: begin
                m = MODE_ERROR;
            end
        endcase
        // A fired kick drops back to idle within the tick
        if (kick) begin
            straight = (i_item.kick_kind == KIND_STRAIGHT);
            power    = (|i_item.kick_strength[15:8]) ? POWER_MAX : i_item.kick_strength[7:0];
            m        = MODE_IDLE;
        end
    end

    assign o_res.burst         = burst;
    assign o_res.kick_fire     = kick;
    assign o_res.kick_direct   = straight;
    assign o_res.kick_power    = power;
    assign o_res.mode          = m;
    assign o_res.charging      = (m == MODE_BUCK) || (m == MODE_BOOST);
    assign o_res.fault         = (m == MODE_ERROR);
    assign o_count             = cnt;

endmodule

@@ rtl/capacitor_charge_sequencer_core.sv @@
// Top level of the capacitor charge sequencer: input stage, step logic, result stage.
//
// Usage:
//   One control tick enters per transfer on the input channel (i_in_valid /
//   o_in_ready) and yields exactly one result on the output channel
//   (o_out_valid / i_out_ready). Configuration is written through i_cfg_we,
//   i_cfg_addr and i_cfg_data while the block is idle; a write lands at once.
//   A tick accepted into the input register passes through the step logic to
//   the result register (two register stages: input register, result register).
//   Throughput: one tick per cycle while i_out_ready is high; the mode and step
//   counter update through compares and one increment between the two registers.
//   Stall: when the receiver holds i_out_ready low the result register holds,
//   the input register still takes one more tick, then o_in_ready drops until
//   the result is taken.
//   Reset (i_rst_n low, synchronous): mode returns to idle, the step count to
//   zero, both stages empty and all configuration registers to their defaults.
module capacitor_charge_sequencer_core
    import ccs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_supply_tenths,
    input  logic [7:0]            i_cap_volts,
    input  logic                  i_charge_enable,
    input  logic [1:0]            i_kick_kind,
    input  logic [15:0]           i_kick_strength,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_burst,
    output logic                  o_kick_fire,
    output logic                  o_kick_direct,
    output logic [7:0]            o_kick_power,
    output logic [2:0]            o_mode,
    output logic                  o_charging,
    output logic                  o_fault
);

    t_cfg               cfg;
    t_item              r_in;
    logic               r_in_valid;
    t_result            r_out;
    logic               r_out_valid;
    t_mode              r_mode;
    logic [COUNT_W-1:0] r_count;
    t_result            n_out;
    logic [COUNT_W-1:0] n_count;
    logic               advance;
    logic               in_xfer;

    ccs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ccs_step_logic u_step (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (n_out),
        .o_count (n_count)
    );

    // Move the held tick into the result stage when that stage frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.supply_tenths <= i_supply_tenths;
            r_in.cap_volts     <= i_cap_volts;
            r_in.charge_enable <= i_charge_enable;
            r_in.kick_kind     <= i_kick_kind;
            r_in.kick_strength <= i_kick_strength;
        end
    end

    // Sequencer state: advance once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
        end else if (advance) begin
            r_mode  <= n_out.mode;
            r_count <= n_count;
        end
    end

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_burst         = r_out.burst;
    assign o_kick_fire     = r_out.kick_fire;
    assign o_kick_direct   = r_out.kick_direct;
    assign o_kick_power    = r_out.kick_power;
    assign o_mode          = r_out.mode;
    assign o_charging      = r_out.charging;
    assign o_fault         = r_out.fault;

    // Error is left only through reset
    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ERROR) |=> (r_mode == MODE_ERROR))
        else $error("sequencer left error mode without reset");

    // State changes only when a tick moves to the result stage
    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !advance) |=> ($stable(r_count) && $stable(r_mode)))
        else $error("sequencer state changed without a tick");

    // A fired kick issues no burst and returns to idle
    a_kick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kick_fire) |->
        (o_burst == BURST_NONE && r_out.mode == MODE_IDLE && !o_charging))
        else $error("kick result with burst or non-idle mode");

    // Presented mode matches the state just stored
    a_mode_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.mode == r_mode))
        else $error("result mode differs from stored mode");

endmodule

@@ verif/tb.sv @@
// Testbench for the capacitor charge sequencer core: random charge ramps checked against a mode predictor.
`timescale 1ns / 1ps

module tb;
    import ccs_pkg::*;

    localparam int QUIET_LIMIT = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_supply_tenths;
    logic [7:0]            i_cap_volts;
    logic                  i_charge_enable;
    logic [1:0]            i_kick_kind;
    logic [15:0]           i_kick_strength;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_burst;
    logic                  o_kick_fire;
    logic                  o_kick_direct;
    logic [7:0]            o_kick_power;
    logic [2:0]            o_mode;
    logic                  o_charging;
    logic                  o_fault;

    // Mirror of the sequencer: configuration, mode and step count, plus pending results
    class charge_tracker;
        t_cfg               cfg;
        t_mode              mode;
        logic [COUNT_W-1:0] steps;
        t_result            pending_results[$];
        int                 fail_count;
        int                 report_count;
        int                 result_count;

        function new();
            cfg.stop_level      = RST_STOP_LEVEL;
            cfg.restart_level   = RST_RESTART_LEVEL;
            cfg.kick_floor      = RST_KICK_FLOOR;
            cfg.supply_low      = RST_SUPPLY_LOW;
            cfg.supply_resume   = RST_SUPPLY_RESUME;
            cfg.boost_margin    = RST_BOOST_MARGIN;
            cfg.max_buck_steps  = RST_MAX_BUCK_STEPS;
            cfg.max_boost_steps = RST_MAX_BOOST_STEPS;
            mode = MODE_IDLE;
            steps = '0;
            fail_count = 0;
            report_count = 0;
            result_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STOP_LEVEL:      cfg.stop_level      = data[7:0];
                CFG_RESTART_LEVEL:   cfg.restart_level   = data[7:0];
                CFG_KICK_FLOOR:      cfg.kick_floor      = data[7:0];
                CFG_SUPPLY_LOW:      cfg.supply_low      = data[7:0];
                CFG_SUPPLY_RESUME:   cfg.supply_resume   = data[7:0];
                CFG_BOOST_MARGIN:    cfg.boost_margin    = data[7:0];
                CFG_MAX_BUCK_STEPS:  cfg.max_buck_steps  = data;
                CFG_MAX_BOOST_STEPS: cfg.max_boost_steps = data;
                default: ;
            endcase
        endfunction

        // Count one converter step, holding at the top
        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
            return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
        endfunction

        // Advance the mirror by one tick and queue the result it must give
        function void note_tick(t_item it);
            t_result     r;
            logic        kick;
            int unsigned boost_point;
            r = '0;
            kick = 1'b0;
            boost_point = int'(it.cap_volts) * 10 + int'(cfg.boost_margin);
            if (!it.charge_enable && mode != MODE_ERROR)
                mode = MODE_IDLE;
            case (mode)
                MODE_IDLE: begin
                    if (it.charge_enable && cfg.supply_resume <= it.supply_tenths) begin
                        steps = '0;
                        mode = MODE_BUCK;
                    end
                end
                MODE_BUCK: begin
                    if (it.supply_tenths <= cfg.supply_low) begin
                        mode = MODE_IDLE;
                    end else if (int'(it.supply_tenths) <= boost_point) begin
                        steps = '0;
                        mode = MODE_BOOST;
                    end else begin
                        steps = bump(steps);
                        if (cfg.max_buck_steps <= steps)
                            mode = MODE_ERROR;
                        r.burst = BURST_BUCK;
                    end
                end
                MODE_BOOST: begin
                    if (it.supply_tenths <= cfg.supply_low) begin
                        mode = MODE_IDLE;
                    end else if (cfg.stop_level <= it.cap_volts) begin
                        mode = MODE_STOP;
                    end else if (cfg.kick_floor <= it.cap_volts && it.kick_kind != KIND_NONE) begin
                        kick = 1'b1;
                    end else begin
                        steps = bump(steps);
                        if (cfg.max_boost_steps <= steps)
                            mode = MODE_ERROR;
                        r.burst = BURST_BOOST;
                    end
                end
                MODE_STOP: begin
                    if (it.cap_volts <= cfg.restart_level) begin
                        steps = '0;
                        mode = MODE_BUCK;
                    end else if (cfg.kick_floor <= it.cap_volts && it.kick_kind != KIND_NONE) begin
                        kick = 1'b1;
                    end
                end
                default: ;
            endcase
            // A fired kick passes straight back to idle
            if (kick) begin
                r.kick_fire = 1'b1;
                r.kick_direct = (it.kick_kind == KIND_STRAIGHT);
                r.kick_power = (it.kick_strength > POWER_MAX) ? POWER_MAX : it.kick_strength[7:0];
                mode = MODE_IDLE;
            end
            r.mode = mode;
            r.charging = (mode == MODE_BUCK || mode == MODE_BOOST);
            r.fault = (mode == MODE_ERROR);
            pending_results.push_back(r);
        endfunction

        function void flag(string what, logic [15:0] want, logic [15:0] got);
            fail_count++;
            if (report_count < 10) begin
                report_count++;
                $display("result %0d %s: expected %0h, got %0h", result_count, what, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                flag("arrived with nothing pending", '0, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.burst !== want.burst)
                flag("burst", 16'(want.burst), 16'(got.burst));
            if (got.kick_fire !== want.kick_fire)
                flag("kick_fire", 16'(want.kick_fire), 16'(got.kick_fire));
            if (got.kick_direct !== want.kick_direct)
                flag("kick_direct", 16'(want.kick_direct), 16'(got.kick_direct));
            if (got.kick_power !== want.kick_power)
                flag("kick_power", 16'(want.kick_power), 16'(got.kick_power));
            if (got.mode !== want.mode)
                flag("mode", 16'(want.mode), 16'(got.mode));
            if (got.charging !== want.charging)
                flag("charging", 16'(want.charging), 16'(got.charging));
            if (got.fault !== want.fault)
                flag("fault", 16'(want.fault), 16'(got.fault));
            result_count++;
        endfunction
    endclass

    charge_tracker sb = new();

    bit in_rush = 1'b0;
    bit out_rush = 1'b0;
    int cap_level = 0;
    int quiet = 0;

    capacitor_charge_sequencer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_supply_tenths (i_supply_tenths),
        .i_cap_volts     (i_cap_volts),
        .i_charge_enable (i_charge_enable),
        .i_kick_kind     (i_kick_kind),
        .i_kick_strength (i_kick_strength),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_burst         (o_burst),
        .o_kick_fire     (o_kick_fire),
        .o_kick_direct   (o_kick_direct),
        .o_kick_power    (o_kick_power),
        .o_mode          (o_mode),
        .o_charging      (o_charging),
        .o_fault         (o_fault)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Drop the run if nothing transfers for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("capacitor_charge_sequencer_core: mismatch");
            $finish;
        end
    end

    // Present one tick after a random gap and hold it until the transfer
    task automatic send_tick(input t_item it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_rush = !in_rush;
        gap = in_rush ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_supply_tenths <= it.supply_tenths;
        i_cap_volts     <= it.cap_volts;
        i_charge_enable <= it.charge_enable;
        i_kick_kind     <= it.kick_kind;
        i_kick_strength <= it.kick_strength;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_tick(it);
    endtask

    task automatic tick(input logic [7:0] supply, input logic [7:0] cap, input logic en,
                        input logic [1:0] kind, input logic [15:0] strength);
        t_item it;
        it.supply_tenths = supply;
        it.cap_volts = cap;
        it.charge_enable = en;
        it.kick_kind = kind;
        it.kick_strength = strength;
        send_tick(it);
    endtask

    // Stop sending and wait until the block has delivered everything
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] upper,
                               input logic [CFG_DATA_W-1:0] lower,
                               input logic [CFG_DATA_W-1:0] kick,
                               input logic [CFG_DATA_W-1:0] low,
                               input logic [CFG_DATA_W-1:0] resume,
                               input logic [CFG_DATA_W-1:0] margin,
                               input logic [CFG_DATA_W-1:0] buck_max,
                               input logic [CFG_DATA_W-1:0] boost_max);
        write_reg(CFG_STOP_LEVEL, upper);
        write_reg(CFG_RESTART_LEVEL, lower);
        write_reg(CFG_KICK_FLOOR, kick);
        write_reg(CFG_SUPPLY_LOW, low);
        write_reg(CFG_SUPPLY_RESUME, resume);
        write_reg(CFG_BOOST_MARGIN, margin);
        write_reg(CFG_MAX_BUCK_STEPS, buck_max);
        write_reg(CFG_MAX_BOOST_STEPS, boost_max);
    endtask

    // Mostly charge ramps with healthy supply, some kicks, and a share of pure noise
    function automatic t_item next_item();
        t_item       it;
        int unsigned lo;
        it.kick_strength = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom());
        if ($urandom_range(0, 6) == 0) begin
            it.supply_tenths = 8'($urandom());
            it.cap_volts = 8'($urandom());
            it.charge_enable = 1'($urandom());
            it.kick_kind = 2'($urandom());
            return it;
        end
        lo = int'(sb.cfg.supply_low) + 1;
        if (lo < sb.cfg.supply_resume)
            lo = sb.cfg.supply_resume;
        if (lo > 255)
            lo = 255;
        it.supply_tenths = ($urandom_range(0, 11) == 0) ? 8'($urandom())
                                                         : 8'($urandom_range(lo, 255));
        it.charge_enable = ($urandom_range(0, 24) != 0);
        it.kick_kind = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : KIND_NONE;
        if ($urandom_range(0, 29) == 0)
            cap_level = $urandom_range(0, 40);
        else if (it.kick_kind != KIND_NONE)
            cap_level = cap_level - $urandom_range(0, 120);
        else
            cap_level = cap_level + $urandom_range(0, 14) - 2;
        if (cap_level < 0)
            cap_level = 0;
        if (cap_level > 255)
            cap_level = 255;
        it.cap_volts = 8'(cap_level);
        return it;
    endfunction

    task automatic random_ticks(input int n);
        repeat (n) send_tick(next_item());
    endtask

    // Accept results after a random stall and check each one
    initial begin
        int      stall;
        t_result got;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_rush = !out_rush;
            stall = out_rush ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.burst = t_burst'(o_burst);
            got.kick_fire = o_kick_fire;
            got.kick_direct = o_kick_direct;
            got.kick_power = o_kick_power;
            got.mode = t_mode'(o_mode);
            got.charging = o_charging;
            got.fault = o_fault;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_supply_tenths <= '0;
        i_cap_volts     <= '0;
        i_charge_enable <= 1'b0;
        i_kick_kind     <= KIND_NONE;
        i_kick_strength <= '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the idle, buck, boost and stop modes at the default limits
        tick(8'd0,   8'd0,   1'b0, KIND_NONE,     16'h0000);
        tick(8'd139, 8'd0,   1'b1, KIND_NONE,     16'h0000);
        tick(8'd140, 8'd0,   1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd0,   1'b1, KIND_NONE,     16'hFFFF);
        tick(8'd131, 8'd11,  1'b1, KIND_NONE,     16'h0000);
        tick(8'd200, 8'd18,  1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd100, 1'b1, KIND_NONE,     16'h00FF);
        tick(8'd255, 8'd150, 1'b1, KIND_STRAIGHT, 16'hFFFF);
        tick(8'd255, 8'd0,   1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd30,  1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd149, 1'b1, KIND_CHIP,     16'h1234);
        tick(8'd255, 8'd200, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd255, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd180, 1'b1, 2'd3,          16'd254);
        tick(8'd255, 8'd200, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd200, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd201, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd197, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd100, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd130, 8'd100, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd0,   1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd255, 1'b0, KIND_STRAIGHT, 16'h5555);
        tick(8'd255, 8'd255, 1'b1, KIND_NONE,     16'h0000);
        tick(8'd255, 8'd255, 1'b1, KIND_CHIP,     16'h0000);
        tick(8'd255, 8'd199, 1'b1, KIND_STRAIGHT, 16'hAAAA);
        random_ticks(80);
        drain();

        // Every threshold at its top, step limits out of reach
        load_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                    COUNT_MAX, COUNT_MAX);
        random_ticks(50);
        drain();

        // Every threshold at zero
        load_config('0, '0, '0, '0, '0, '0, COUNT_MAX, COUNT_MAX);
        random_ticks(50);
        drain();

        // Two random settings
        repeat (2) begin
            load_config(13'($urandom()), 13'($urandom()), 13'($urandom()), 13'($urandom()),
                        13'($urandom()), 13'($urandom()), 13'($urandom_range(1000, 8191)),
                        13'($urandom_range(1000, 8191)));
            random_ticks(80);
            drain();
        end

        // Tight step limit on one converter: error is final, so this goes last
        if ($urandom_range(0, 1) != 0)
            load_config(13'(RST_STOP_LEVEL), 13'(RST_RESTART_LEVEL), 13'(RST_KICK_FLOOR),
                        13'(RST_SUPPLY_LOW), 13'(RST_SUPPLY_RESUME), 13'(RST_BOOST_MARGIN),
                        13'($urandom_range(0, 3)), COUNT_MAX);
        else
            load_config(13'(RST_STOP_LEVEL), 13'(RST_RESTART_LEVEL), 13'(RST_KICK_FLOOR),
                        13'(RST_SUPPLY_LOW), 13'(RST_SUPPLY_RESUME), 13'(RST_BOOST_MARGIN),
                        COUNT_MAX, 13'($urandom_range(0, 3)));
        random_ticks(60);
        drain();

        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
            $display("capacitor_charge_sequencer_core: match");
        else
            $display("capacitor_charge_sequencer_core: mismatch");
        $finish;
    end

endmodule
